// ===== rtl/audio_one_pole_filter_path_unit_macros.svh =====
// Assertion macros for the one-pole filter path.
// Used by the top level only; no other dependencies.
`ifndef AUDIO_ONE_POLE_FILTER_PATH_UNIT_MACROS_SVH
`define AUDIO_ONE_POLE_FILTER_PATH_UNIT_MACROS_SVH

// same-cycle implication
`define AOPF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AOPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aopf_pkg.sv =====
// Shared types, widths and helpers for the one-pole filter path.
// No dependencies.
`default_nettype none

package aopf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = 32;
    localparam int ALPHA_W    = 16;
    localparam int DECIM_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SAT_IN_W   = ACC_W + 5;

    localparam logic [DECIM_W-1:0]         DECIM_RESET = 8'd16;
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX     = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN     = 16'sh8000;

    typedef enum logic [1:0] {
        MODE_PASS     = 2'd0,
        MODE_LOWPASS  = 2'd1,
        MODE_HIGHPASS = 2'd2,
        MODE_SPECTRUM = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ALPHA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DECIM = 2'd2;

    typedef struct packed {
        t_mode              mode;
        logic [ALPHA_W-1:0] alpha;
        logic [DECIM_W-1:0] decim;
    } t_cfg;

    // saturate a widened accumulator value to the signed state range
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SAT_IN_W-1:0] v);
        logic fits;
        fits = (v[SAT_IN_W-1:ACC_W-1] == '0) || (v[SAT_IN_W-1:ACC_W-1] == '1);
        if (fits) begin
            return v[ACC_W-1:0];
        end else if (v[SAT_IN_W-1]) begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/aopf_filter.sv =====
// Mono mix plus lowpass/highpass one-pole filters with their state.
// Depends on aopf_pkg.
`default_nettype none

module aopf_filter #(
    parameter int STATE_FRAC_BITS = 24
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_step,
    input  wire aopf_pkg::t_cfg                       i_cfg,
    input  wire logic signed [aopf_pkg::SAMPLE_W-1:0] i_left_sample,
    input  wire logic signed [aopf_pkg::SAMPLE_W-1:0] i_right_sample,
    output logic signed [aopf_pkg::ACC_W-1:0]         o_value
);

    localparam int SHIFT = STATE_FRAC_BITS - 15;
    localparam int AW    = aopf_pkg::ACC_W;
    localparam int SW    = aopf_pkg::SAMPLE_W;
    localparam int SIW   = aopf_pkg::SAT_IN_W;

    logic signed [AW-1:0] r_lp, n_lp;
    logic signed [AW-1:0] r_hp, n_hp;
    logic signed [SW-1:0] r_prev;

    logic signed [SW-1:0]   mono;
    logic signed [AW-1:0]   x;
    logic signed [AW-1:0]   x_prev;
    logic signed [aopf_pkg::ALPHA_W:0] a_s;
    logic signed [AW:0]     lp_diff;
    logic signed [AW+17:0]  lp_prod;
    logic signed [AW+1:0]   hp_diff;
    logic signed [AW+18:0]  hp_prod;

    assign mono   = SW'(17'(i_left_sample >>> 1) + 17'(i_right_sample >>> 1));
    assign x      = AW'(mono) <<< SHIFT;
    assign x_prev = AW'(r_prev) <<< SHIFT;
    assign a_s    = $signed({1'b0, i_cfg.alpha});

    // y + a*(x - y) / 2^15, floor
    assign lp_diff = (AW+1)'(x) - (AW+1)'(r_lp);
    assign lp_prod = (AW+18)'(a_s) * (AW+18)'(lp_diff);
    assign n_lp    = aopf_pkg::sat_acc(SIW'(r_lp) + SIW'(lp_prod >>> 15));

    // a*(y + x - x_prev) / 2^15, floor
    assign hp_diff = (AW+2)'(r_hp) + (AW+2)'(x) - (AW+2)'(x_prev);
    assign hp_prod = (AW+19)'(a_s) * (AW+19)'(hp_diff);
    assign n_hp    = aopf_pkg::sat_acc(SIW'(hp_prod >>> 15));

    always_comb begin
        case (i_cfg.mode)
            aopf_pkg::MODE_LOWPASS:  o_value = n_lp;
            aopf_pkg::MODE_HIGHPASS: o_value = n_hp;
            default:                 o_value = x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp   <= '0;
            r_hp   <= '0;
            r_prev <= '0;
        end else if (i_step) begin
            case (i_cfg.mode)
                aopf_pkg::MODE_LOWPASS: begin
                    r_lp <= n_lp;
                end
                aopf_pkg::MODE_HIGHPASS: begin
                    r_hp   <= n_hp;
                    r_prev <= mono;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/aopf_tap.sv =====
// Decimation counter that flags every Nth word as the display tap.
// Depends on aopf_pkg.
`default_nettype none

module aopf_tap (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire aopf_pkg::t_cfg i_cfg,
    output logic                o_tap
);

    localparam int DW = aopf_pkg::DECIM_W;

    logic [DW-1:0] r_count, n_count;
    logic [DW-1:0] period;
    logic [DW-1:0] inc;

    assign period = (i_cfg.decim == '0) ? DW'(1) : i_cfg.decim;
    assign inc    = r_count + DW'(1);
    assign o_tap  = (inc >= period);
    assign n_count = o_tap ? '0 : inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_step) begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/aopf_scale.sv =====
// Clamp of a state-format value to [-1,1] and scaling to a 16-bit sample.
// Depends on aopf_pkg.
`default_nettype none

module aopf_scale #(
    parameter int STATE_FRAC_BITS = 24
) (
    input  wire logic signed [aopf_pkg::ACC_W-1:0] i_value,
    output logic signed [aopf_pkg::SAMPLE_W-1:0]   o_sample
);

    localparam int PW = aopf_pkg::ACC_W + 16;
    localparam logic signed [aopf_pkg::ACC_W-1:0] STATE_ONE = 32'sd1 <<< STATE_FRAC_BITS;
    localparam logic signed [PW-1:0] BIAS = (PW'(1) <<< STATE_FRAC_BITS) - PW'(1);

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] quot;

    // v*32767 as (v << 15) - v, truncated toward zero
    assign prod = (PW'(i_value) <<< 15) - PW'(i_value);
    assign quot = prod[PW-1] ? ((prod + BIAS) >>> STATE_FRAC_BITS)
                             : (prod >>> STATE_FRAC_BITS);

    always_comb begin
        if (i_value >= STATE_ONE) begin
            o_sample = aopf_pkg::OUT_MAX;
        end else if (i_value <= -STATE_ONE) begin
            o_sample = aopf_pkg::OUT_MIN;
        end else begin
            o_sample = quot[aopf_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/audio_one_pole_filter_path_unit.sv =====
// Top level of the mono mix and one-pole filter path.
// Depends on aopf_pkg, aopf_filter, aopf_tap, aopf_scale and the macros header.
//
// Takes one stereo word per cycle and returns one mono word per cycle while the output
// side does not stall. Each word passes through the input register, the filter stage
// whose accumulator loop closes through a single alpha multiply, and a scaling stage
// into the output register. A full pipeline holds three words; an output stall holds a
// stage only while the stage after it is full. Configuration is taken at any cycle on
// the write port and must only change while the path is empty.
`default_nettype none
`include "audio_one_pole_filter_path_unit_macros.svh"

module audio_one_pole_filter_path_unit #(
    parameter int STATE_FRAC_BITS = 24
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_in_valid,
    output logic                                          o_in_ready,
    input  wire logic signed [aopf_pkg::SAMPLE_W-1:0]     i_left_sample,
    input  wire logic signed [aopf_pkg::SAMPLE_W-1:0]     i_right_sample,
    output logic                                          o_out_valid,
    input  wire logic                                     i_out_ready,
    output logic signed [aopf_pkg::SAMPLE_W-1:0]          o_out_sample,
    output logic                                          o_tap_valid,
    input  wire logic                                     i_cfg_we,
    input  wire logic [aopf_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  wire logic [aopf_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    aopf_pkg::t_cfg r_cfg;

    logic                                 r_in_valid;
    logic signed [aopf_pkg::SAMPLE_W-1:0] r_left;
    logic signed [aopf_pkg::SAMPLE_W-1:0] r_right;

    logic                                 r_mid_valid;
    logic signed [aopf_pkg::ACC_W-1:0]    r_mid_value;
    logic                                 r_mid_tap;

    logic                                 r_out_valid;
    logic signed [aopf_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                                 r_out_tap;

    logic                                 out_adv;
    logic                                 mid_adv;
    logic                                 in_adv;
    logic                                 step;
    logic signed [aopf_pkg::ACC_W-1:0]    w_value;
    logic                                 w_tap;
    logic signed [aopf_pkg::SAMPLE_W-1:0] w_sample;

    assign out_adv = !r_out_valid || i_out_ready;
    assign mid_adv = !r_mid_valid || out_adv;
    assign in_adv  = !r_in_valid || mid_adv;
    assign step    = r_in_valid && mid_adv;

    assign o_in_ready   = in_adv;
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_tap_valid  = r_out_tap;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= aopf_pkg::MODE_PASS;
            r_cfg.alpha <= '0;
            r_cfg.decim <= aopf_pkg::DECIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aopf_pkg::CFG_IDX_MODE:  r_cfg.mode  <= aopf_pkg::t_mode'(i_cfg_data[1:0]);
                aopf_pkg::CFG_IDX_ALPHA: r_cfg.alpha <= i_cfg_data[aopf_pkg::ALPHA_W-1:0];
                aopf_pkg::CFG_IDX_DECIM: r_cfg.decim <= i_cfg_data[aopf_pkg::DECIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    aopf_filter #(
        .STATE_FRAC_BITS(STATE_FRAC_BITS)
    ) u_filter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_cfg          (r_cfg),
        .i_left_sample  (r_left),
        .i_right_sample (r_right),
        .o_value        (w_value)
    );

    aopf_tap u_tap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cfg   (r_cfg),
        .o_tap   (w_tap)
    );

    aopf_scale #(
        .STATE_FRAC_BITS(STATE_FRAC_BITS)
    ) u_scale (
        .i_value  (r_mid_value),
        .o_sample (w_sample)
    );

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_in_valid;
            end
            if (mid_adv) begin
                r_mid_valid <= r_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_left  <= i_left_sample;
            r_right <= i_right_sample;
        end
        if (step) begin
            r_mid_value <= w_value;
            r_mid_tap   <= w_tap;
        end
        if (out_adv && r_mid_valid) begin
            r_out_sample <= w_sample;
            r_out_tap    <= r_mid_tap;
        end
    end

    `AOPF_ASSERT_NOW(a_full_stall_blocks_input, i_clk, i_rst_n,
        r_in_valid && r_mid_valid && r_out_valid && !i_out_ready, !o_in_ready,
        "input accepted while the full pipeline is stalled")

    `AOPF_ASSERT_NOW(a_unit_period_taps_all, i_clk, i_rst_n,
        step && (r_cfg.decim == 8'd0 || r_cfg.decim == 8'd1), w_tap,
        "word not tapped with a decimation period of one")

    `AOPF_ASSERT_NEXT(a_mid_reaches_output, i_clk, i_rst_n,
        r_mid_valid && out_adv, o_out_valid,
        "filtered word lost on the way to the output register")

endmodule

`default_nettype wire
